>>> rtl/arm_instruction_decoder_assert.svh
// Assertion macros for the instruction decoder.
`ifndef ARM_INSTRUCTION_DECODER_ASSERT_SVH
`define ARM_INSTRUCTION_DECODER_ASSERT_SVH

`ifndef SYNTH
`define AID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed");
`define AID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder check failed");
`else
`define AID_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AID_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/aid_pkg.sv
`default_nettype none

package aid_pkg;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_DATA,
    CLS_LDST,
    CLS_BRANCH,
    CLS_BRANCH_LINK,
    CLS_BLOCK,
    CLS_SWI,
    CLS_FAULT
  } instr_class_t;

  typedef enum logic [2:0] {
    FLT_NONE,
    FLT_COND,
    FLT_MISC,
    FLT_MEDIA,
    FLT_COPROC,
    FLT_RSC
  } fault_code_t;

  typedef enum logic [3:0] {
    CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
    CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
  } cond_code_t;

  localparam logic [3:0] OP_RSC = 4'd7;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam int FLG_SET  = 0;
  localparam int FLG_LOAD = 1;
  localparam int FLG_BYTE = 2;
  localparam int FLG_PRE  = 3;
  localparam int FLG_UP   = 4;
  localparam int FLG_WB   = 5;
  localparam int FLG_REG  = 6;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic         passed;
    instr_class_t cls;
    fault_code_t  fault;
  } aid_class_t;

endpackage

`default_nettype wire

>>> rtl/aid_classify.sv
`default_nettype none

module aid_classify (
  input  wire logic [31:0]        instr,
  input  wire logic [3:0]         flags,
  output aid_pkg::aid_class_t     result
);
  import aid_pkg::*;

  logic       n, z, c, v;
  logic       cond_ok;
  cond_code_t cond;

  assign n    = flags[3];
  assign z    = flags[2];
  assign c    = flags[1];
  assign v    = flags[0];
  assign cond = cond_code_t'(instr[31:28]);

  always_comb begin
    case (cond)
      CC_EQ:   cond_ok = z;
      CC_NE:   cond_ok = !z;
      CC_CS:   cond_ok = c;
      CC_CC:   cond_ok = !c;
      CC_MI:   cond_ok = n;
      CC_PL:   cond_ok = !n;
      CC_VS:   cond_ok = v;
      CC_VC:   cond_ok = !v;
      CC_HI:   cond_ok = c && !z;
      CC_LS:   cond_ok = !c || z;
      CC_GE:   cond_ok = n == v;
      CC_LT:   cond_ok = n != v;
      CC_GT:   cond_ok = !z && (n == v);
      CC_LE:   cond_ok = z || (n != v);
      default: cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    result.passed = 1'b1;
    result.cls    = CLS_FAULT;
    result.fault  = FLT_NONE;
    if (cond == CC_NV) begin
      result.passed = 1'b0;
      result.fault  = FLT_COND;
    end else if (!cond_ok) begin
      result.passed = 1'b0;
      result.cls    = CLS_SKIP;
    end else begin
      case (instr[27:26])
        2'b00: begin
          if (instr[24] && !instr[23] && !instr[20]) begin
            result.fault = FLT_MISC;
          end else if (instr[24:21] == OP_RSC) begin
            result.fault = FLT_RSC;
          end else begin
            result.cls = CLS_DATA;
          end
        end
        2'b01: begin
          if (instr[25] && instr[4]) begin
            result.fault = FLT_MEDIA;
          end else begin
            result.cls = CLS_LDST;
          end
        end
        2'b10: begin
          if (instr[25]) begin
            result.cls = instr[24] ? CLS_BRANCH_LINK : CLS_BRANCH;
          end else begin
            result.cls = CLS_BLOCK;
          end
        end
        default: begin
          if (instr[25] && instr[24]) begin
            result.cls = CLS_SWI;
          end else begin
            result.fault = FLT_COPROC;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/arm_instruction_decoder.sv
`default_nettype none
`include "arm_instruction_decoder_assert.svh"

// Channel  Dir  Ports                  Contents
// in       in   in_tvalid/tready/tdata  instruction, condition_flags
// out      out  out_tvalid/tready/...   decoded control word, class in tuser
//
// Three register stages: input capture, condition check and class, field decode.
// One item a cycle sustained while out_tready is held high.
// Each stage holds its item while the stage after it is full and stalled,
// so a bubble is taken up even while the output waits.
// Synchronous active-low reset clears the stage valid bits only.

module arm_instruction_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [31:0] instruction, [35:32] condition_flags, [39:36] zero
  input  wire logic [aid_pkg::IN_DATA_W-1:0]    in_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [0] condition_passed, [4:1] operation, [7:5] fault_code,
  // [14:8] access_flags, [18:15] base_reg, [22:19] dest_reg,
  // [38:23] operand_value, [40:39] shift_type, [45:41] shift_amount,
  // [69:46] branch_offset, [70] writes_pc, [71] zero
  output      logic [aid_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [2:0] instr_class
  output      logic [2:0]                       out_tuser
);
  import aid_pkg::*;

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  logic [31:0] s1_instr_r;
  logic [3:0]  s1_flags_r;
  logic [31:0] s2_instr_r;
  aid_class_t  s2_class_r;
  aid_class_t  class_nxt;

  logic         passed_nxt, passed_r;
  instr_class_t cls_nxt, cls_r;
  logic [3:0]   op_nxt, op_r;
  fault_code_t  fault_nxt, fault_r;
  logic [6:0]   acc_nxt, acc_r;
  logic [3:0]   base_nxt, base_r;
  logic [3:0]   dest_nxt, dest_r;
  logic [15:0]  operand_nxt, operand_r;
  logic [1:0]   stype_nxt, stype_r;
  logic [4:0]   samt_nxt, samt_r;
  logic [23:0]  boff_nxt, boff_r;
  logic         wpc_nxt, wpc_r;

  logic [31:0] w;
  logic        wb;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  aid_classify u_classify (
    .instr  (s1_instr_r),
    .flags  (s1_flags_r),
    .result (class_nxt)
  );

  assign w = s2_instr_r;

  always_comb begin
    passed_nxt  = s2_class_r.passed;
    cls_nxt     = s2_class_r.cls;
    fault_nxt   = s2_class_r.fault;
    op_nxt      = '0;
    acc_nxt     = '0;
    base_nxt    = '0;
    dest_nxt    = '0;
    operand_nxt = '0;
    stype_nxt   = '0;
    samt_nxt    = '0;
    boff_nxt    = '0;
    wpc_nxt     = 1'b0;
    wb          = 1'b0;
    case (s2_class_r.cls)
      CLS_DATA: begin
        op_nxt            = w[24:21];
        base_nxt          = w[19:16];
        dest_nxt          = w[15:12];
        acc_nxt[FLG_SET]  = w[20];
        acc_nxt[FLG_REG]  = !w[25];
        if (!w[25]) begin
          operand_nxt = {12'd0, w[3:0]};
          stype_nxt   = w[6:5];
          samt_nxt    = w[11:7];
        end else begin
          operand_nxt = {8'd0, w[7:0]};
          stype_nxt   = 2'd3;
          samt_nxt    = {w[11:8], 1'b0};
        end
        wpc_nxt = (w[15:12] == REG_PC) && (w[24:23] != 2'b10);
      end
      CLS_LDST: begin
        wb                = !w[24] || w[21];
        base_nxt          = w[19:16];
        dest_nxt          = w[15:12];
        acc_nxt[FLG_LOAD] = w[20];
        acc_nxt[FLG_BYTE] = w[22];
        acc_nxt[FLG_PRE]  = w[24];
        acc_nxt[FLG_UP]   = w[23];
        acc_nxt[FLG_WB]   = wb;
        acc_nxt[FLG_REG]  = w[25];
        if (w[25]) begin
          operand_nxt = {12'd0, w[3:0]};
          stype_nxt   = w[6:5];
          samt_nxt    = w[11:7];
        end else begin
          operand_nxt = {4'd0, w[11:0]};
        end
        wpc_nxt = (w[20] && (w[15:12] == REG_PC)) || (wb && (w[19:16] == REG_PC));
      end
      CLS_BRANCH, CLS_BRANCH_LINK: begin
        boff_nxt = w[23:0];
        wpc_nxt  = 1'b1;
      end
      CLS_BLOCK: begin
        wb                = w[21];
        base_nxt          = w[19:16];
        acc_nxt[FLG_LOAD] = w[20];
        acc_nxt[FLG_PRE]  = w[24];
        acc_nxt[FLG_UP]   = w[23];
        acc_nxt[FLG_WB]   = wb;
        operand_nxt       = w[15:0];
        wpc_nxt = (w[20] && w[15]) || (wb && (w[19:16] == REG_PC));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && rdy1) begin
      s1_instr_r <= in_tdata[31:0];
      s1_flags_r <= in_tdata[35:32];
    end
    if (v1_r && rdy2) begin
      s2_instr_r <= s1_instr_r;
      s2_class_r <= class_nxt;
    end
    if (v2_r && rdy3) begin
      passed_r  <= passed_nxt;
      cls_r     <= cls_nxt;
      op_r      <= op_nxt;
      fault_r   <= fault_nxt;
      acc_r     <= acc_nxt;
      base_r    <= base_nxt;
      dest_r    <= dest_nxt;
      operand_r <= operand_nxt;
      stype_r   <= stype_nxt;
      samt_r    <= samt_nxt;
      boff_r    <= boff_nxt;
      wpc_r     <= wpc_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tuser  = cls_r;
  assign out_tdata  = {1'b0, wpc_r, boff_r, samt_r, stype_r, operand_r,
                       dest_r, base_r, acc_r, fault_r, op_r, passed_r};

  `AID_ASSERT_NOW(a_skip_zero, clk, rst_n, out_tvalid && (cls_r == CLS_SKIP),
    out_tdata == '0)
  `AID_ASSERT_NOW(a_fault_code, clk, rst_n, out_tvalid,
    (cls_r == CLS_FAULT) == (fault_r != FLT_NONE))
  `AID_ASSERT_NOW(a_branch_pc, clk, rst_n,
    out_tvalid && (cls_r == CLS_BRANCH || cls_r == CLS_BRANCH_LINK), wpc_r)
  `AID_ASSERT_NOW(a_not_passed, clk, rst_n, out_tvalid && !passed_r,
    cls_r == CLS_SKIP || (cls_r == CLS_FAULT && fault_r == FLT_COND))
  `AID_ASSERT_NEXT(a_stage_hold, clk, rst_n, v2_r && v3_r && !out_tready,
    v2_r && v3_r)

endmodule

`default_nettype wire

>>> tb/sv/aid_decode_check.sv
module aid_decode_check
  import aid_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_DATA_W-1:0]   out_tdata,
  input  logic [2:0]              out_tuser,
  output int                      n_pending,
  output int                      n_fail
);

  typedef struct packed {
    logic         passed;
    instr_class_t cls;
    logic [3:0]   op;
    fault_code_t  fault;
    logic [6:0]   flags;
    logic [3:0]   rn;
    logic [3:0]   rd;
    logic [15:0]  operand;
    logic [1:0]   sh_type;
    logic [4:0]   sh_amt;
    logic [23:0]  offset;
    logic         wpc;
  } ctrl_word_t;

  ctrl_word_t ctrl_q[$];
  int         n_err = 0;

  function automatic ctrl_word_t fault_word(logic passed, fault_code_t code);
    ctrl_word_t d;
    d = '0;
    d.passed = passed;
    d.cls = CLS_FAULT;
    d.fault = code;
    return d;
  endfunction

  function automatic ctrl_word_t decode_word(logic [31:0] w, logic [3:0] fl);
    ctrl_word_t d;
    cond_code_t cc;
    logic       n, z, c, v, ok, load, wb;
    logic [3:0] op;
    d = '0;
    cc = cond_code_t'(w[31:28]);
    {n, z, c, v} = fl;
    op = w[24:21];
    if (cc == CC_NV) return fault_word(1'b0, FLT_COND);
    case (cc)
      CC_EQ: ok = z;
      CC_NE: ok = !z;
      CC_CS: ok = c;
      CC_CC: ok = !c;
      CC_MI: ok = n;
      CC_PL: ok = !n;
      CC_VS: ok = v;
      CC_VC: ok = !v;
      CC_HI: ok = c && !z;
      CC_LS: ok = !c || z;
      CC_GE: ok = n == v;
      CC_LT: ok = n != v;
      CC_GT: ok = !z && (n == v);
      CC_LE: ok = z || (n != v);
      default: ok = 1'b1;
    endcase
    if (!ok) return d;
    d.passed = 1'b1;
    case (w[27:26])
      2'b00: begin
        if (w[24] && !w[23] && !w[20]) return fault_word(1'b1, FLT_MISC);
        if (op == OP_RSC) return fault_word(1'b1, FLT_RSC);
        d.flags[FLG_SET] = w[20];
        if (!w[25]) begin
          d.flags[FLG_REG] = 1'b1;
          d.operand = {12'd0, w[3:0]};
          d.sh_type = w[6:5];
          d.sh_amt = w[11:7];
        end else begin
          d.operand = {8'd0, w[7:0]};
          d.sh_type = 2'd3;
          d.sh_amt = {w[11:8], 1'b0};
        end
        d.cls = CLS_DATA;
        d.op = op;
        d.rn = w[19:16];
        d.rd = w[15:12];
        d.wpc = (w[15:12] == REG_PC) && (op < 4'd8 || op > 4'd11);
      end
      2'b01: begin
        if (w[25] && w[4]) return fault_word(1'b1, FLT_MEDIA);
        load = w[20];
        wb = !w[24] || w[21];
        d.flags[FLG_LOAD] = load;
        d.flags[FLG_BYTE] = w[22];
        d.flags[FLG_PRE] = w[24];
        d.flags[FLG_UP] = w[23];
        d.flags[FLG_WB] = wb;
        if (w[25]) begin
          d.flags[FLG_REG] = 1'b1;
          d.operand = {12'd0, w[3:0]};
          d.sh_type = w[6:5];
          d.sh_amt = w[11:7];
        end else begin
          d.operand = {4'd0, w[11:0]};
        end
        d.cls = CLS_LDST;
        d.rn = w[19:16];
        d.rd = w[15:12];
        d.wpc = (load && w[15:12] == REG_PC) || (wb && w[19:16] == REG_PC);
      end
      2'b10: begin
        if (w[25]) begin
          d.cls = w[24] ? CLS_BRANCH_LINK : CLS_BRANCH;
          d.offset = w[23:0];
          d.wpc = 1'b1;
        end else begin
          load = w[20];
          wb = w[21];
          d.flags[FLG_LOAD] = load;
          d.flags[FLG_PRE] = w[24];
          d.flags[FLG_UP] = w[23];
          d.flags[FLG_WB] = wb;
          d.cls = CLS_BLOCK;
          d.rn = w[19:16];
          d.operand = w[15:0];
          d.wpc = (load && w[15]) || (wb && w[19:16] == REG_PC);
        end
      end
      default: begin
        if (w[25] && w[24]) d.cls = CLS_SWI;
        else return fault_word(1'b1, FLT_COPROC);
      end
    endcase
    return d;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      n_err++;
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    ctrl_word_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (ctrl_q.size() == 0) begin
          n_err++;
          $error("result item with no instruction outstanding");
        end else begin
          e = ctrl_q.pop_front();
          check_field("condition_passed", e.passed, out_tdata[0]);
          check_field("instr_class", e.cls, out_tuser);
          check_field("operation", e.op, out_tdata[4:1]);
          check_field("fault_code", e.fault, out_tdata[7:5]);
          check_field("access_flags", e.flags, out_tdata[14:8]);
          check_field("base_reg", e.rn, out_tdata[18:15]);
          check_field("dest_reg", e.rd, out_tdata[22:19]);
          check_field("operand_value", e.operand, out_tdata[38:23]);
          check_field("shift_type", e.sh_type, out_tdata[40:39]);
          check_field("shift_amount", e.sh_amt, out_tdata[45:41]);
          check_field("branch_offset", e.offset, out_tdata[69:46]);
          check_field("writes_pc", e.wpc, out_tdata[70]);
        end
      end
      if (in_tvalid && in_tready)
        ctrl_q.push_back(decode_word(in_tdata[31:0], in_tdata[35:32]));
    end
    n_pending <= ctrl_q.size();
    n_fail <= n_err;
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import aid_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [2:0]              out_tuser;
  int                      n_pending;
  int                      n_fail;
  logic                    calm = 1'b0;
  logic                    long_hold = 1'b0;

  arm_instruction_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  aid_decode_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .n_pending  (n_pending),
    .n_fail     (n_fail)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_instr(input logic [31:0] w, input logic [3:0] fl);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, fl, w};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // mostly unconditional words so decode is reached; PC registers now and then
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) < 6) w[31:28] = CC_AL;
    if ($urandom_range(0, 7) == 0) w[15:12] = REG_PC;
    if ($urandom_range(0, 7) == 0) w[19:16] = REG_PC;
    return w;
  endfunction

  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (long_hold) begin
        stall = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_instr(32'h0000_0000, 4'h0);
    send_instr(32'h0000_0000, 4'h4);
    send_instr(32'hFFFF_FFFF, 4'hF);
    send_instr(32'hF000_0000, 4'h0);
    send_instr(32'h8A00_0000, 4'h2);
    send_instr(32'hD000_0000, 4'h8);
    send_instr(32'hC000_0000, 4'h8);
    send_instr(32'hE091_2F83, 4'h0);
    send_instr(32'hE3A0_F0FF, 4'h0);
    send_instr(32'hE3E0_0FFF, 4'hF);
    send_instr(32'hE15F_F00F, 4'h0);
    send_instr(32'hE100_0000, 4'h0);
    send_instr(32'hE0E0_0000, 4'h0);
    send_instr(32'hE2E0_0000, 4'h0);
    send_instr(32'hE600_0010, 4'h0);
    send_instr(32'hE790_0001, 4'h0);
    send_instr(32'hE59F_F004, 4'h0);
    send_instr(32'hE4CF_0FFF, 4'h0);
    send_instr(32'hEA80_0000, 4'h0);
    send_instr(32'hEA7F_FFFF, 4'h0);
    send_instr(32'hEBFF_FFFF, 4'h0);
    send_instr(32'hE8BD_8000, 4'h0);
    send_instr(32'hE92F_0001, 4'h0);
    send_instr(32'hE810_FFFF, 4'h0);
    send_instr(32'hEFFF_FFFF, 4'h0);
    send_instr(32'hEC00_0000, 4'h0);
    send_instr(32'hEE00_0010, 4'h0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 1 || ph == 2 || ph == 5);
      long_hold = (ph == 2 || ph == 5);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_instr(rand_instr(), 4'($urandom_range(0, 15)));
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> arm_instruction_decoder.f
+incdir+rtl
rtl/aid_pkg.sv
rtl/aid_classify.sv
rtl/arm_instruction_decoder.sv
tb/sv/aid_decode_check.sv
tb/sv/testbench.sv
